// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/cpu8alu_pkg.sv =====
// Package with the operation codes, flag positions and word types of the 8-bit ALU.
package cpu8alu_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_AND = 5'd2,
    OP_OR  = 5'd3,
    OP_XOR = 5'd4,
    OP_INC = 5'd5,
    OP_DEC = 5'd6,
    OP_BIT = 5'd7,
    OP_RES = 5'd8,
    OP_SET = 5'd9,
    OP_RLC = 5'd10,
    OP_RRC = 5'd11,
    OP_RL  = 5'd12,
    OP_RR  = 5'd13,
    OP_SLA = 5'd14,
    OP_SRA = 5'd15,
    OP_SLL = 5'd16,
    OP_SRL = 5'd17
  } alu_op_t;

  // Flag byte layout: S Z Y H X P/V N C.
  localparam int unsigned FL_C  = 0;
  localparam int unsigned FL_N  = 1;
  localparam int unsigned FL_PV = 2;
  localparam int unsigned FL_X  = 3;
  localparam int unsigned FL_H  = 4;
  localparam int unsigned FL_Y  = 5;
  localparam int unsigned FL_Z  = 6;
  localparam int unsigned FL_S  = 7;

  localparam logic [7:0] INC_OVF_VALUE = 8'h80;
  localparam logic [7:0] DEC_OVF_VALUE = 8'h7f;
  localparam logic [3:0] NIBBLE_ZERO   = 4'h0;
  localparam logic [3:0] NIBBLE_FULL   = 4'hf;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic       carry_in;
    logic [2:0] bit_index;
    logic [7:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [7:0] flags_out;
  } alu_rsp_t;

endpackage

// ===== src/cpu8alu_core.sv =====
// Combinational datapath of the 8-bit ALU: result byte and flag byte for one word.
module cpu8alu_core (
  input  cpu8alu_pkg::alu_req_t req,
  output cpu8alu_pkg::alu_rsp_t rsp
);
  import cpu8alu_pkg::*;

  logic [8:0] sum9;
  logic [8:0] dif9;
  logic [7:0] inc8;
  logic [7:0] dec8;
  logic [7:0] mask;
  logic [7:0] a;
  logic [7:0] b;
  logic       cf;
  logic [7:0] r;
  logic [7:0] f;

  // S, Z, Y and X taken from a byte.
  function automatic logic [7:0] szxy(input logic [7:0] z);
    logic [7:0] fl;
    fl        = 8'h00;
    fl[FL_S]  = z[7];
    fl[FL_Y]  = z[5];
    fl[FL_X]  = z[3];
    fl[FL_Z]  = (z == 8'h00);
    return fl;
  endfunction

  // Flags of logic, bit test and shift operations; P/V is even parity.
  function automatic logic [7:0] logic_flags(input logic [7:0] z, input logic h,
                                             input logic c);
    logic [7:0] fl;
    fl        = szxy(z);
    fl[FL_PV] = ~(^z);
    fl[FL_H]  = h;
    fl[FL_C]  = c;
    return fl;
  endfunction

  always_comb begin
    a    = req.operand_a;
    b    = req.operand_b;
    cf   = req.flags_in[FL_C];
    sum9 = {1'b0, a} + {1'b0, b} + {8'h00, req.carry_in};
    dif9 = {1'b0, a} - {1'b0, b} - {8'h00, req.carry_in};
    inc8 = a + 8'd1;
    dec8 = a - 8'd1;
    mask = 8'h01 << req.bit_index;
    r    = a;
    f    = req.flags_in;
    unique case (req.kind)
      OP_ADD: begin
        r         = sum9[7:0];
        f         = szxy(r);
        f[FL_H]   = a[4] ^ b[4] ^ sum9[4];
        f[FL_PV]  = ~(a[7] ^ b[7]) & (a[7] ^ sum9[7]);
        f[FL_C]   = sum9[8];
      end
      OP_SUB: begin
        r         = dif9[7:0];
        f         = szxy(r);
        f[FL_H]   = a[4] ^ b[4] ^ dif9[4];
        f[FL_PV]  = (a[7] ^ b[7]) & (a[7] ^ dif9[7]);
        f[FL_N]   = 1'b1;
        f[FL_C]   = dif9[8];
      end
      OP_AND: begin
        r = a & b;
        f = logic_flags(r, 1'b1, 1'b0);
      end
      OP_OR: begin
        r = a | b;
        f = logic_flags(r, 1'b0, 1'b0);
      end
      OP_XOR: begin
        r = a ^ b;
        f = logic_flags(r, 1'b0, 1'b0);
      end
      OP_INC: begin
        r        = inc8;
        f        = szxy(r);
        f[FL_C]  = cf;
        f[FL_PV] = (r == INC_OVF_VALUE);
        f[FL_H]  = (r[3:0] == NIBBLE_ZERO);
      end
      OP_DEC: begin
        r        = dec8;
        f        = szxy(r);
        f[FL_C]  = cf;
        f[FL_N]  = 1'b1;
        f[FL_PV] = (r == DEC_OVF_VALUE);
        f[FL_H]  = (r[3:0] == NIBBLE_FULL);
      end
      OP_BIT: begin
        r = a;
        f = logic_flags(a & mask, 1'b1, cf);
      end
      OP_RES: r = a & ~mask;
      OP_SET: r = a | mask;
      OP_RLC: begin
        r = {a[6:0], a[7]};
        f = logic_flags(r, 1'b0, a[7]);
      end
      OP_RRC: begin
        r = {a[0], a[7:1]};
        f = logic_flags(r, 1'b0, a[0]);
      end
      OP_RL: begin
        r = {a[6:0], cf};
        f = logic_flags(r, 1'b0, a[7]);
      end
      OP_RR: begin
        r = {cf, a[7:1]};
        f = logic_flags(r, 1'b0, a[0]);
      end
      OP_SLA: begin
        r = {a[6:0], 1'b0};
        f = logic_flags(r, 1'b0, a[7]);
      end
      OP_SRA: begin
        r = {a[7], a[7:1]};
        f = logic_flags(r, 1'b0, a[0]);
      end
      OP_SLL: begin
        r = {a[6:0], 1'b1};
        f = logic_flags(r, 1'b0, a[7]);
      end
      OP_SRL: begin
        r = {1'b0, a[7:1]};
        f = logic_flags(r, 1'b0, a[0]);
      end
      default: begin
        // Codes without an operation pass the operand and flags through.
        r = a;
        f = req.flags_in;
      end
    endcase
    rsp.result    = r;
    rsp.flags_out = f;
  end

endmodule

// ===== src/cpu8_alu_with_flags_unit.sv =====
// Top level of the 8-bit ALU with flags: input register, datapath, result register.
//
// This unit is the 8-bit ALU of a classic 8-bit processor. Each request word
// carries an operation code (add, sub, and, or, xor, inc, dec, bit, res, set
// and the eight rotates and shifts), two operand bytes, a carry in, a bit
// index and the current flag byte; the response word carries the result byte
// and the new flag byte in the layout S Z Y H X P/V N C. Inc and dec keep
// carry, res and set leave every flag alone, bit takes X and Y from the
// masked value, and an undefined operation code returns operand_a and the
// incoming flags unchanged. Both channels use a valid/ready handshake. A
// request word is captured in an input register, goes through one shallow
// combinational pass of the datapath and lands in the result register,
// from which it is valid on the response side until it is taken. While
// the response side does not stall, the unit takes one word every cycle;
// while it stalls, the input register still takes one more word before
// the request side is held off.
// There is no configuration and no state across words, and reset only clears
// the two valid bits.
module cpu8_alu_with_flags_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [4:0] kind,
  input  logic [7:0] operand_a,
  input  logic [7:0] operand_b,
  input  logic       carry_in,
  input  logic [2:0] bit_index,
  input  logic [7:0] flags_in,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic [7:0] result,
  output logic [7:0] flags_out
);
  import cpu8alu_pkg::*;

  // Input register stage.
  logic     stage_valid;
  alu_req_t stage_req;

  // Result register stage.
  logic     out_valid;
  alu_rsp_t out_rsp;

  alu_rsp_t core_rsp;
  logic     out_free;
  logic     stage_free;

  // The result register can load when it is empty or its word leaves now;
  // the input register can load when it is empty or its word moves on now.
  assign out_free   = !out_valid || rsp_ready;
  assign stage_free = !stage_valid || out_free;
  assign req_ready  = stage_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_free) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_free && req_valid) begin
      stage_req <= '{kind:      kind,
                     operand_a: operand_a,
                     operand_b: operand_b,
                     carry_in:  carry_in,
                     bit_index: bit_index,
                     flags_in:  flags_in};
    end
  end

  cpu8alu_core u_core (
    .req (stage_req),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && stage_valid) begin
      out_rsp <= core_rsp;
    end
  end

  assign rsp_valid = out_valid;
  assign result    = out_rsp.result;
  assign flags_out = out_rsp.flags_out;

endmodule

// ===== src/cpu8alu_checker.sv =====
// Port-level checker of the 8-bit ALU and its bind to the top level.
`include "assert_macros.svh"

module cpu8alu_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] result,
  input logic [7:0] flags_out
);

  // A stalled response word holds its value.
  `ASSERT_CLK_RST(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(result) && $stable(flags_out), "response word changed while stalled")

  // No response word right after reset.
  `ASSERT_CLK(a_rst_empty, clk, rst |=> !rsp_valid, "response valid after reset")

  // Requests are held off only by a stalled response.
  `ASSERT_CLK_RST(a_ready_stall, clk, rst, !req_ready |-> rsp_valid && !rsp_ready, "request side blocked without a response stall")

  // A fresh response word comes from a request accepted earlier.
  `ASSERT_CLK_RST(a_rsp_source, clk, rst, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response word without a request")

endmodule

bind cpu8_alu_with_flags_unit cpu8alu_checker u_checker (.*);

// ===== tb/sv/alu_flag_checker.sv =====
// Checker that predicts the ALU response words and compares them with the unit's output.
`timescale 1ns / 100ps

module alu_flag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [4:0]  kind,
  input  logic [7:0]  operand_a,
  input  logic [7:0]  operand_b,
  input  logic        carry_in,
  input  logic [2:0]  bit_index,
  input  logic [7:0]  flags_in,
  input  logic        rsp_valid,
  input  logic        rsp_ready,
  input  logic [7:0]  result,
  input  logic [7:0]  flags_out,
  output int unsigned fail_count,
  output int unsigned pending_words
);
  import cpu8alu_pkg::*;

  localparam int unsigned SHOWN_MAX = 10;

  typedef struct packed {
    alu_req_t req;
    alu_rsp_t rsp;
  } alu_outcome_t;

  alu_outcome_t outcome_q[$];
  int unsigned  fails = 0;

  // Sign, zero and the two undocumented copy bits, all taken from one byte.
  function automatic logic [7:0] sign_zero_copy(input logic [7:0] v);
    logic [7:0] f;
    f        = '0;
    f[FL_S]  = v[7];
    f[FL_Y]  = v[5];
    f[FL_X]  = v[3];
    f[FL_Z]  = (v == 8'h00);
    return f;
  endfunction

  // Flags shared by the logic ops, bit test and the shifts: P/V is even parity.
  function automatic logic [7:0] parity_flags(input logic [7:0] v, input logic h,
                                              input logic c);
    logic [7:0] f;
    f         = sign_zero_copy(v);
    f[FL_PV]  = ~^v;
    f[FL_H]   = h;
    f[FL_C]   = c;
    return f;
  endfunction

  function automatic alu_rsp_t alu_outcome(input alu_req_t rq);
    logic [8:0] wide;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic [7:0] f;
    logic [7:0] mask;
    logic       cf;
    alu_rsp_t   o;
    a    = rq.operand_a;
    b    = rq.operand_b;
    r    = a;
    f    = rq.flags_in;
    cf   = rq.flags_in[FL_C];
    mask = 8'h01 << rq.bit_index;
    case (rq.kind)
      OP_ADD: begin
        wide      = {1'b0, a} + {1'b0, b} + {8'h00, rq.carry_in};
        r         = wide[7:0];
        f         = sign_zero_copy(r);
        f[FL_H]   = a[4] ^ b[4] ^ wide[4];
        f[FL_PV]  = (a[7] == b[7]) && (a[7] != r[7]);
        f[FL_C]   = wide[8];
      end
      OP_SUB: begin
        wide      = {1'b0, a} - {1'b0, b} - {8'h00, rq.carry_in};
        r         = wide[7:0];
        f         = sign_zero_copy(r);
        f[FL_H]   = a[4] ^ b[4] ^ wide[4];
        f[FL_PV]  = (a[7] != b[7]) && (a[7] != r[7]);
        f[FL_N]   = 1'b1;
        f[FL_C]   = wide[8];
      end
      OP_AND: begin
        r = a & b;
        f = parity_flags(r, 1'b1, 1'b0);
      end
      OP_OR: begin
        r = a | b;
        f = parity_flags(r, 1'b0, 1'b0);
      end
      OP_XOR: begin
        r = a ^ b;
        f = parity_flags(r, 1'b0, 1'b0);
      end
      OP_INC: begin
        r         = a + 8'h01;
        f         = sign_zero_copy(r);
        f[FL_C]   = cf;
        f[FL_PV]  = (r == INC_OVF_VALUE);
        f[FL_H]   = (r[3:0] == NIBBLE_ZERO);
      end
      OP_DEC: begin
        r         = a - 8'h01;
        f         = sign_zero_copy(r);
        f[FL_C]   = cf;
        f[FL_N]   = 1'b1;
        f[FL_PV]  = (r == DEC_OVF_VALUE);
        f[FL_H]   = (r[3:0] == NIBBLE_FULL);
      end
      OP_BIT: f = parity_flags(a & mask, 1'b1, cf);
      OP_RES: r = a & ~mask;
      OP_SET: r = a | mask;
      OP_RLC: begin
        r = {a[6:0], a[7]};
        f = parity_flags(r, 1'b0, a[7]);
      end
      OP_RRC: begin
        r = {a[0], a[7:1]};
        f = parity_flags(r, 1'b0, a[0]);
      end
      OP_RL: begin
        r = {a[6:0], cf};
        f = parity_flags(r, 1'b0, a[7]);
      end
      OP_RR: begin
        r = {cf, a[7:1]};
        f = parity_flags(r, 1'b0, a[0]);
      end
      OP_SLA: begin
        r = {a[6:0], 1'b0};
        f = parity_flags(r, 1'b0, a[7]);
      end
      OP_SRA: begin
        r = {a[7], a[7:1]};
        f = parity_flags(r, 1'b0, a[0]);
      end
      OP_SLL: begin
        r = {a[6:0], 1'b1};
        f = parity_flags(r, 1'b0, a[7]);
      end
      OP_SRL: begin
        r = {1'b0, a[7:1]};
        f = parity_flags(r, 1'b0, a[0]);
      end
      default: begin
        r = a;
        f = rq.flags_in;
      end
    endcase
    o.result    = r;
    o.flags_out = f;
    return o;
  endfunction

  always @(posedge clk) begin : watch
    alu_outcome_t oc;
    alu_req_t     rq;
    if (rst) begin
      outcome_q.delete();
    end else begin
      if (req_valid && req_ready) begin
        rq.kind      = kind;
        rq.operand_a = operand_a;
        rq.operand_b = operand_b;
        rq.carry_in  = carry_in;
        rq.bit_index = bit_index;
        rq.flags_in  = flags_in;
        oc.req       = rq;
        oc.rsp       = alu_outcome(rq);
        outcome_q.push_back(oc);
      end
      if (rsp_valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          fails++;
          if (fails <= SHOWN_MAX)
            $display("%0t: response word with nothing outstanding: result %02h flags %02h",
                     $realtime, result, flags_out);
        end else begin
          oc = outcome_q.pop_front();
          if (result !== oc.rsp.result || flags_out !== oc.rsp.flags_out) begin
            fails++;
            if (fails <= SHOWN_MAX)
              $display("%0t: kind %0d a %02h b %02h ci %0b bit %0d fin %02h:",
                       $realtime, oc.req.kind, oc.req.operand_a, oc.req.operand_b,
                       oc.req.carry_in, oc.req.bit_index, oc.req.flags_in,
                       " result exp %02h got %02h, flags exp %02h got %02h",
                       oc.rsp.result, result, oc.rsp.flags_out, flags_out);
          end
        end
      end
    end
    fail_count    <= fails;
    pending_words <= unsigned'(outcome_q.size());
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the ALU testbench: clock, reset, request and response traffic, and the verdict.
`timescale 1ns / 100ps

module tb_top;
  import cpu8alu_pkg::*;

  // Operation codes past the last defined one; the unit must pass these through.
  localparam logic [4:0]  OP_UNDEF_LO  = OP_SRL + 5'd1;
  localparam logic [4:0]  OP_UNDEF_HI  = 5'h1f;
  localparam int unsigned RANDOM_WORDS = 430;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE       = 8;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  logic [4:0] kind      = '0;
  logic [7:0] operand_a = '0;
  logic [7:0] operand_b = '0;
  logic       carry_in  = 1'b0;
  logic [2:0] bit_index = '0;
  logic [7:0] flags_in  = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  logic [7:0] result;
  logic [7:0] flags_out;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cpu8_alu_with_flags_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .kind      (kind),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .carry_in  (carry_in),
    .bit_index (bit_index),
    .flags_in  (flags_in),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .result    (result),
    .flags_out (flags_out)
  );

  // The checker sees both channels exactly as the unit does and keeps the
  // count of failures; this module only drives traffic and reads that count.
  alu_flag_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .kind          (kind),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .carry_in      (carry_in),
    .bit_index     (bit_index),
    .flags_in      (flags_in),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .result        (result),
    .flags_out     (flags_out),
    .fail_count    (fail_count),
    .pending_words (pending_words)
  );

  // Reset is held at the start and never again.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog. A correct run needs far fewer cycles than this, even with the
  // longest receiver stalls, so reaching the limit means the unit hung.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Present one request word and hold it until the unit takes it. Called
  // right after a rising edge; returns right after the edge of acceptance.
  // All drives are nonblocking, so sampling req_ready here sees the value
  // that the unit itself used at this edge.
  task automatic offer_word(input logic [4:0] k, input logic [7:0] a, input logic [7:0] b,
                            input logic ci, input logic [2:0] bi, input logic [7:0] fl);
    req_valid <= 1'b1;
    kind      <= k;
    operand_a <= a;
    operand_b <= b;
    carry_in  <= ci;
    bit_index <= bi;
    flags_in  <= fl;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic idle_gap(input int unsigned cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stop offering and wait until the checker holds no outstanding word. The
  // first edge is always waited out, because the count is registered and lags
  // the acceptance that it reflects.
  task automatic drain_words();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  // Byte with a bias toward the values where carries and overflows happen.
  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [5];
    corner = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff};
    if ($urandom_range(0, 7) == 0)
      return corner[$urandom_range(0, 4)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly defined operations, with a tenth undefined codes so that the top
  // bit of kind and the pass-through path are exercised.
  function automatic logic [4:0] pick_kind();
    if ($urandom_range(0, 9) == 0)
      return 5'($urandom_range(int'(OP_UNDEF_LO), int'(OP_UNDEF_HI)));
    return 5'($urandom_range(int'(OP_ADD), int'(OP_SRL)));
  endfunction

  // Response side. It starts ready, then refuses words for a long stretch
  // while the directed words are still being offered, so the result and
  // input registers both fill and the unit must hold off its request side.
  // After that it runs a pattern of its own: stretches of full readiness,
  // stretches of random readiness at a random duty, and now and then
  // another long refusal.
  initial begin : rsp_side
    int unsigned pick;
    int unsigned stretch;
    int unsigned duty;
    int unsigned hold;
    while (rst) @(posedge clk);
    rsp_ready <= 1'b1;
    repeat (12) @(posedge clk);
    rsp_ready <= 1'b0;
    hold = 48;
    for (int unsigned n = 0; n < hold; n++) @(posedge clk);
    forever begin
      pick    = $urandom_range(0, 9);
      stretch = $urandom_range(8, 40);
      if (pick == 0) begin
        rsp_ready <= 1'b0;
        hold = $urandom_range(30, 60);
        for (int unsigned n = 0; n < hold; n++) @(posedge clk);
      end else if (pick < 4) begin
        rsp_ready <= 1'b1;
        repeat (stretch) @(posedge clk);
      end else begin
        duty = $urandom_range(20, 85);
        repeat (stretch) begin
          rsp_ready <= ($urandom_range(1, 100) <= duty);
          @(posedge clk);
        end
      end
    end
  end

  // Request side: a directed burst, a full drain, random bursts with a
  // second drain halfway, and the final drain before the verdict.
  initial begin : req_side
    int unsigned sent;
    int unsigned burst;
    bit          mid_drained;
    while (rst) @(posedge clk);

    // Directed words, back to back. Flags in of the defined operations are all
    // ones or all zeros so that pass-through and kept bits are visible.
    offer_word(OP_ADD, 8'h7f, 8'h00, 1'b1, 3'd0, 8'h00);  // overflow and half carry
    offer_word(OP_ADD, 8'hff, 8'h01, 1'b0, 3'd0, 8'hff);  // carry out, zero result
    offer_word(OP_SUB, 8'h80, 8'h01, 1'b0, 3'd0, 8'h00);  // signed overflow
    offer_word(OP_SUB, 8'h00, 8'h00, 1'b1, 3'd0, 8'hff);  // borrow with carry in
    offer_word(OP_AND, 8'hff, 8'hff, 1'b0, 3'd0, 8'h00);
    offer_word(OP_OR,  8'h00, 8'h00, 1'b1, 3'd0, 8'hff);
    offer_word(OP_XOR, 8'haa, 8'h55, 1'b0, 3'd0, 8'h00);
    offer_word(OP_INC, 8'h7f, 8'h00, 1'b0, 3'd0, 8'hff);  // inc into 0x80
    offer_word(OP_INC, 8'hff, 8'h00, 1'b0, 3'd0, 8'h00);  // wrap to zero, carry kept
    offer_word(OP_DEC, 8'h80, 8'h00, 1'b0, 3'd0, 8'hff);  // dec into 0x7f
    offer_word(OP_DEC, 8'h00, 8'h00, 1'b0, 3'd0, 8'h00);
    offer_word(OP_BIT, 8'h80, 8'h00, 1'b0, 3'd7, 8'hff);  // bit set, sign from mask
    offer_word(OP_BIT, 8'h28, 8'hff, 1'b1, 3'd0, 8'h00);  // copy bits must not leak
    offer_word(OP_RES, 8'hff, 8'h00, 1'b0, 3'd7, 8'h00);
    offer_word(OP_SET, 8'h00, 8'h00, 1'b0, 3'd0, 8'hff);
    offer_word(OP_RLC, 8'h80, 8'h00, 1'b0, 3'd0, 8'h00);
    offer_word(OP_RRC, 8'h01, 8'h00, 1'b0, 3'd0, 8'hff);
    offer_word(OP_RL,  8'h80, 8'h00, 1'b0, 3'd0, 8'hff);  // carry in from flags
    offer_word(OP_RR,  8'h01, 8'h00, 1'b0, 3'd0, 8'h00);
    offer_word(OP_SLA, 8'hff, 8'h00, 1'b0, 3'd0, 8'h00);
    offer_word(OP_SRA, 8'h81, 8'h00, 1'b0, 3'd0, 8'hff);  // sign bit kept
    offer_word(OP_SLL, 8'h80, 8'h00, 1'b0, 3'd0, 8'h00);  // one shifted into bit 0
    offer_word(OP_SRL, 8'h01, 8'h00, 1'b0, 3'd0, 8'hff);
    offer_word(OP_UNDEF_LO, 8'h5a, 8'ha5, 1'b1, 3'd5, 8'h3c);
    offer_word(OP_UNDEF_HI, 8'ha5, 8'h5a, 1'b0, 3'd2, 8'hc3);
    drain_words();

    // Random bursts. A gap of zero lets two bursts run together.
    sent        = 0;
    mid_drained = 1'b0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        offer_word(pick_kind(), pick_byte(), pick_byte(), 1'($urandom_range(0, 1)),
                   3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
      sent += burst;
      if (!mid_drained && sent >= RANDOM_WORDS / 2) begin
        drain_words();
        mid_drained = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_gap($urandom_range(1, 10));
      end
    end

    drain_words();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
